>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clock, with and without reset masking.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define SRU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check prop at every rising edge, reset included.
`define SRU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> hw/rtl/sru_pkg.sv
// ---------------------------------------------------------------------------
// sru_pkg
// Shared types, operation codes and register indexes of the shift, rotate
// and bit unit.
// ---------------------------------------------------------------------------
package sru_pkg;

   localparam int unsigned RegCount      = 7;
   localparam int unsigned RegIndexWidth = 3;
   localparam int unsigned DataWidth     = 8;
   localparam int unsigned AddrWidth     = 16;

   typedef logic [3:0]               kind_type;
   typedef logic [RegIndexWidth-1:0] reg_index_type;
   typedef logic [DataWidth-1:0]     byte_type;

   localparam kind_type KIND_RLCA = 4'd0;
   localparam kind_type KIND_RLA  = 4'd1;
   localparam kind_type KIND_RRCA = 4'd2;
   localparam kind_type KIND_RRA  = 4'd3;
   localparam kind_type KIND_RLC  = 4'd4;
   localparam kind_type KIND_RRC  = 4'd5;
   localparam kind_type KIND_RL   = 4'd6;
   localparam kind_type KIND_RR   = 4'd7;
   localparam kind_type KIND_SLA  = 4'd8;
   localparam kind_type KIND_SRA  = 4'd9;
   localparam kind_type KIND_SRL  = 4'd10;
   localparam kind_type KIND_SWAP = 4'd11;
   localparam kind_type KIND_BIT  = 4'd12;
   localparam kind_type KIND_RES  = 4'd13;
   localparam kind_type KIND_SET  = 4'd14;
   localparam kind_type KIND_LOAD = 4'd15;

   localparam reg_index_type TGT_A   = 3'd0;
   localparam reg_index_type TGT_H   = 3'd5;
   localparam reg_index_type TGT_L   = 3'd6;
   localparam reg_index_type TGT_MEM = 3'd7;

   localparam byte_type SIGN_BIT_MASK = 8'h80;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      byte_type      result;
      flags_type     flags;
      logic          reg_we;
      reg_index_type reg_index;
      logic          mem_we;
   } exec_type;

endpackage

>>> hw/rtl/sru_regfile.sv
// ---------------------------------------------------------------------------
// sru_regfile
// Register file memory: one synchronous read port, one write port, with
// per-entry valid bits so that unwritten entries read as zero.
// ---------------------------------------------------------------------------
module sru_regfile (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  sru_pkg::reg_index_type rd_addr,
   output sru_pkg::byte_type      rd_data,
   input  logic                   wr_en,
   input  sru_pkg::reg_index_type wr_addr,
   input  sru_pkg::byte_type      wr_data
);
   import sru_pkg::*;

   byte_type              mem [RegCount];
   logic [RegCount-1:0]   valid_ff;
   byte_type              rd_data_ff;
   logic                  rd_valid_ff;
   logic                  rd_in_range;

   assign rd_in_range = (rd_addr < RegIndexWidth'(RegCount));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= rd_in_range ? valid_ff[rd_addr] : 1'b0;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> hw/rtl/sru_exec.sv
// ---------------------------------------------------------------------------
// sru_exec
// Operation unit: computes the new operand value, the flags and the write
// targets of one instruction.
// ---------------------------------------------------------------------------
module sru_exec (
   input  sru_pkg::kind_type      kind,
   input  sru_pkg::reg_index_type target,
   input  logic [2:0]             bit_index,
   input  sru_pkg::byte_type      data_byte,
   input  sru_pkg::byte_type      reg_value,
   input  sru_pkg::flags_type     flags_cur,
   output sru_pkg::exec_type      ex
);
   import sru_pkg::*;

   logic      is_acc;
   logic      to_memory;
   byte_type  op;
   byte_type  mask;
   byte_type  result;
   flags_type flags;
   logic      writes;
   logic      load_reg;

   assign is_acc    = (kind == KIND_RLCA) || (kind == KIND_RLA) ||
                      (kind == KIND_RRCA) || (kind == KIND_RRA);
   assign to_memory = !is_acc && (target == TGT_MEM) && (kind != KIND_LOAD);
   assign op        = to_memory ? data_byte : reg_value;
   assign mask      = byte_type'(1) << bit_index;

   always_comb begin
      result   = op;
      flags    = flags_cur;
      writes   = 1'b1;
      load_reg = 1'b0;
      unique case (kind)
         KIND_RLCA, KIND_RLC: begin
            result = {op[6:0], op[7]};
            flags  = '{z: (result == '0), n: 1'b0, h: 1'b0, c: op[7]};
         end
         KIND_RLA, KIND_RL: begin
            result = {op[6:0], flags_cur.c};
            flags  = '{z: (result == '0), n: 1'b0, h: 1'b0, c: op[7]};
         end
         KIND_RRCA, KIND_RRC: begin
            result = {op[0], op[7:1]};
            flags  = '{z: (result == '0), n: 1'b0, h: 1'b0, c: op[0]};
         end
         KIND_RRA, KIND_RR: begin
            result = {flags_cur.c, op[7:1]};
            flags  = '{z: (result == '0), n: 1'b0, h: 1'b0, c: op[0]};
         end
         KIND_SLA: begin
            result = {op[6:0], 1'b0};
            flags  = '{z: (result == '0), n: 1'b0, h: 1'b0, c: op[7]};
         end
         KIND_SRA: begin
            result = (op & SIGN_BIT_MASK) | (op >> 1);
            flags  = '{z: (result == '0), n: 1'b0, h: 1'b0, c: op[0]};
         end
         KIND_SRL: begin
            result = op >> 1;
            flags  = '{z: (result == '0), n: 1'b0, h: 1'b0, c: op[0]};
         end
         KIND_SWAP: begin
            result = {op[3:0], op[7:4]};
            flags  = '{z: (result == '0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         KIND_BIT: begin
            result = op;
            flags  = '{z: ((op & mask) == '0), n: 1'b0, h: 1'b1, c: flags_cur.c};
            writes = 1'b0;
         end
         KIND_RES: begin
            result = op & ~mask;
         end
         KIND_SET: begin
            result = op | mask;
         end
         default: begin
            result   = data_byte;
            writes   = 1'b0;
            load_reg = (target != TGT_MEM);
            if (target == TGT_MEM) begin
               flags = flags_type'(data_byte[7:4]);
            end
         end
      endcase
      if (is_acc) begin
         flags.z = 1'b0;
      end
   end

   assign ex.result    = result;
   assign ex.flags     = flags;
   assign ex.reg_we    = (writes && !to_memory) || load_reg;
   assign ex.reg_index = is_acc ? TGT_A : target;
   assign ex.mem_we    = writes && to_memory;

endmodule

>>> hw/rtl/cpu_shift_rotate_bit_unit_core.sv
// ---------------------------------------------------------------------------
// cpu_shift_rotate_bit_unit_core
// Shift, rotate and bit instruction unit with a memory-held register file.
// ---------------------------------------------------------------------------
// One instruction is accepted every cycle unless a held response stalls
// the execute stage. An accepted transaction first reads its operand
// from the register file memory synchronously; the execute stage then
// computes the result, writes it back with the flags and loads the
// output register. A write of the preceding transaction to the register
// being read is forwarded, so dependent instructions run back to back.
// H:L and the flags are held in flip-flops next to the memory.
// ---------------------------------------------------------------------------
module cpu_shift_rotate_bit_unit_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sru_pkg::kind_type      req_kind,
   input  logic [2:0]             req_target,
   input  logic [2:0]             req_bit_index,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_result_value,
   output logic                   rsp_memory_write,
   output logic [15:0]            rsp_memory_address,
   output logic                   rsp_zero_out,
   output logic                   rsp_subtract_out,
   output logic                   rsp_half_carry_out,
   output logic                   rsp_carry_out
);
   import sru_pkg::*;
   `include "assert_macros.svh"

   logic                 req_fire;
   logic                 s1_go;
   reg_index_type        rd_addr;
   byte_type             rd_data;
   byte_type             reg_value;
   exec_type             ex;
   logic                 wr_en;

   logic                 s1_valid_ff, s1_valid_in;
   kind_type             s1_kind_ff;
   reg_index_type        s1_target_ff;
   logic [2:0]           s1_bit_ff;
   byte_type             s1_data_ff;
   logic                 fwd_hit_ff;
   byte_type             fwd_data_ff;
   flags_type            flags_ff, flags_in;
   logic [AddrWidth-1:0] hl_ff, hl_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   byte_type             rsp_result_ff;
   logic                 rsp_mem_we_ff;
   logic [AddrWidth-1:0] rsp_addr_ff;
   flags_type            rsp_flags_ff;

   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;

   assign rd_addr = (req_kind == KIND_RLCA || req_kind == KIND_RLA ||
                     req_kind == KIND_RRCA || req_kind == KIND_RRA) ? TGT_A : req_target;

   sru_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (ex.reg_index),
      .wr_data (ex.result)
   );

   assign reg_value = fwd_hit_ff ? fwd_data_ff : rd_data;

   sru_exec u_exec (
      .kind      (s1_kind_ff),
      .target    (s1_target_ff),
      .bit_index (s1_bit_ff),
      .data_byte (s1_data_ff),
      .reg_value (reg_value),
      .flags_cur (flags_ff),
      .ex        (ex)
   );

   assign wr_en = s1_go && ex.reg_we;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      flags_in = s1_go ? ex.flags : flags_ff;
      hl_in    = hl_ff;
      if (wr_en && ex.reg_index == TGT_H) begin
         hl_in[15:8] = ex.result;
      end
      if (wr_en && ex.reg_index == TGT_L) begin
         hl_in[7:0] = ex.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         flags_ff     <= '0;
         hl_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
         hl_ff        <= hl_in;
         if (req_fire) begin
            fwd_hit_ff <= wr_en && (ex.reg_index == rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff   <= req_kind;
         s1_target_ff <= req_target;
         s1_bit_ff    <= req_bit_index;
         s1_data_ff   <= req_data_byte;
         fwd_data_ff  <= ex.result;
      end
      if (s1_go) begin
         rsp_result_ff <= ex.result;
         rsp_mem_we_ff <= ex.mem_we;
         rsp_addr_ff   <= hl_ff;
         rsp_flags_ff  <= ex.flags;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_result_ff;
   assign rsp_memory_write   = rsp_mem_we_ff;
   assign rsp_memory_address = rsp_addr_ff;
   assign rsp_zero_out       = rsp_flags_ff.z;
   assign rsp_subtract_out   = rsp_flags_ff.n;
   assign rsp_half_carry_out = rsp_flags_ff.h;
   assign rsp_carry_out      = rsp_flags_ff.c;

   `SRU_ASSERT(a_go_fills_output, s1_go |=> rsp_valid_ff, "result lost after execute")
   `SRU_ASSERT(a_h_shadow, (wr_en && ex.reg_index == TGT_H) |=> (hl_ff[15:8] == $past(ex.result)), "H shadow out of step")
   `SRU_ASSERT(a_single_dest, (s1_go && ex.mem_we) |-> !ex.reg_we, "memory and register both written")
   `SRU_ASSERT(a_hold_stage, (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_kind_ff)), "stalled stage changed")

endmodule
